### rtl/energy_aware_route_table_unit_assert.svh
// Assertion macros for the route table unit.
`ifndef ENERGY_AWARE_ROUTE_TABLE_UNIT_ASSERT_SVH
`define ENERGY_AWARE_ROUTE_TABLE_UNIT_ASSERT_SVH

`define EART_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define EART_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/eart_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eart_pkg;
   localparam int TableEntriesDefault = 16;
   localparam int ReqDataWidth = 88;
   localparam int RspDataWidth = 112;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_BEST   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DIV,
      FSM_WRITE,
      FSM_FETCH,
      FSM_RESP
   } fsm_type;
endpackage
`default_nettype wire

### rtl/eart_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module eart_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [23:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [23:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[31]};
      trial   = shifted - {9'd0, dvs_ff};
      if (start) begin
         rem_in  = 32'd0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

### rtl/energy_aware_route_table_unit.sv
`timescale 1ns / 1ps
// Route table of TABLE_ENTRIES slots keyed by neighbor id. One command at a
// time: an add takes a scan of all slots (one slot per cycle), a 32-step
// serial divide for the score and a write (an add that finds a duplicate or
// no free slot skips both); delete, find and select best take one slot-scan
// and a fetch or fail step. req_tready is low while a command is in flight or
// its result waits; the result beat sits in an output register until taken.
`default_nettype none
`include "energy_aware_route_table_unit_assert.svh"
module energy_aware_route_table_unit #(
   parameter int TABLE_ENTRIES = eart_pkg::TableEntriesDefault
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // cmd, node_id, min_energy, hop_total, avg_energy, traffic_load, path_budget
   input  wire logic [eart_pkg::ReqDataWidth-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status, hit_route_id, hit_min_energy, hit_hops, hit_avg_energy,
   // hit_traffic, hit_score, hit_shortest
   output logic [eart_pkg::RspDataWidth-1:0]      rsp_tdata
);
   import eart_pkg::*;

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CntW = $clog2(TABLE_ENTRIES + 1);

   logic [15:0] m_hop  [TABLE_ENTRIES];
   logic [15:0] m_emin [TABLE_ENTRIES];
   logic [7:0]  m_hops [TABLE_ENTRIES];
   logic [15:0] m_avg  [TABLE_ENTRIES];
   logic [15:0] m_tra  [TABLE_ENTRIES];
   logic [31:0] m_score[TABLE_ENTRIES];
   logic [15:0] m_stamp[TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] short_ff, short_in;

   fsm_type     state_ff, state_in;
   logic [CntW-1:0] idx_ff, idx_in;
   cmd_type     cmd_ff, cmd_in;
   logic [15:0] id_ff, id_in, emin_ff, emin_in, avg_ff, avg_in, tra_ff, tra_in;
   logic [7:0]  hops_ff, hops_in, bud_ff, bud_in;
   logic        found_ff, found_in, free_ok_ff, free_ok_in;
   logic        any_ff, any_in, anys_ff, anys_in;
   logic [IdxW-1:0] hit_ff, hit_in, free_ff, free_in;
   logic [31:0] bscore_ff, bscore_in;
   logic [15:0] bstamp_ff, bstamp_in, hstamp_ff, hstamp_in;
   logic        rv_ff, rv_in;
   logic [RspDataWidth-1:0] rd_ff, rd_in;
   logic [15:0] icnt_ff, icnt_in;

   logic [IdxW-1:0] ix;
   logic        vld;
   logic [19:0] lhs;
   logic        qual;
   logic        add_go, del_go;
   logic [31:0] score;
   logic [23:0] dvsr;
   logic        div_start;
   logic        div_done;
   logic [31:0] dq;

   assign ix   = idx_ff[IdxW-1:0];
   assign vld  = valid_ff[ix];
   assign lhs  = {1'b0, m_emin[ix], 3'd0} + {3'd0, m_emin[ix], 1'b0};
   assign qual = vld && (m_score[ix] != 32'd0) && (lhs > {4'd0, m_avg[ix]});
   assign dvsr = hops_ff * tra_ff;

   eart_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend({avg_ff, 16'd0}), .divisor(dvsr),
      .done(div_done), .quotient(dq)
   );

   always_comb begin
      if (dvsr == 24'd0) score = 32'hFFFF_FFFF;
      else score = dq;
   end

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; cmd_in = cmd_ff; id_in = id_ff;
      emin_in = emin_ff; avg_in = avg_ff; tra_in = tra_ff; hops_in = hops_ff;
      bud_in = bud_ff; found_in = found_ff; free_ok_in = free_ok_ff;
      any_in = any_ff; anys_in = anys_ff; hit_in = hit_ff; free_in = free_ff;
      bscore_in = bscore_ff; bstamp_in = bstamp_ff; hstamp_in = hstamp_ff;
      rv_in = rv_ff; rd_in = rd_ff; icnt_in = icnt_ff;
      valid_in = valid_ff; short_in = short_ff;
      div_start = 1'b0; add_go = 1'b0; del_go = 1'b0;
      req_tready = (state_ff == FSM_IDLE) && !rv_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in  = cmd_type'(req_tdata[1:0]);
               id_in   = req_tdata[17:2];
               emin_in = req_tdata[33:18];
               hops_in = req_tdata[41:34];
               avg_in  = req_tdata[57:42];
               tra_in  = req_tdata[73:58];
               bud_in  = req_tdata[81:74];
               idx_in  = '0; found_in = 1'b0; free_ok_in = 1'b0;
               any_in = 1'b0; anys_in = 1'b0;
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (cmd_ff == CMD_BEST) begin
               if (qual && (!found_ff || m_score[ix] > bscore_ff ||
                   (m_score[ix] == bscore_ff && m_stamp[ix] < bstamp_ff))) begin
                  found_in = 1'b1; hit_in = ix;
                  bscore_in = m_score[ix]; bstamp_in = m_stamp[ix];
               end
            end else if (vld) begin
               any_in = 1'b1;
               if (short_ff[ix]) anys_in = 1'b1;
               if (m_hop[ix] == id_ff && !found_ff) begin
                  found_in = 1'b1; hit_in = ix; hstamp_in = m_stamp[ix];
               end
            end else if (!free_ok_ff) begin
               free_ok_in = 1'b1; free_in = ix;
            end
            idx_in = idx_ff + CntW'(1);
            if (idx_ff == CntW'(TABLE_ENTRIES - 1)) begin
               if (cmd_ff == CMD_ADD) begin
                  if (found_in || !free_ok_in) state_in = FSM_RESP;
                  else begin
                     div_start = 1'b1; state_in = FSM_DIV;
                  end
               end else state_in = found_in ? FSM_FETCH : FSM_RESP;
               idx_in = '0;
            end
         end
         FSM_DIV: if (div_done) state_in = FSM_WRITE;
         FSM_WRITE: begin
            add_go = 1'b1;
            valid_in[free_ff] = 1'b1;
            short_in[free_ff] = !any_ff ? 1'b1 :
               ((bud_ff != 8'd0 && !bud_ff[7]) ? !anys_ff : 1'b0);
            icnt_in = icnt_ff + 16'd1;
            rd_in = RspDataWidth'({short_in[free_ff], score, tra_ff, avg_ff, hops_ff,
                                   emin_ff, id_ff, ST_OK});
            rv_in = 1'b1; state_in = FSM_IDLE;
         end
         FSM_FETCH: begin
            rd_in = RspDataWidth'({short_ff[hit_ff], m_score[hit_ff], m_tra[hit_ff],
                                   m_avg[hit_ff], m_hops[hit_ff], m_emin[hit_ff],
                                   m_hop[hit_ff], ST_OK});
            if (cmd_ff == CMD_DELETE) begin
               del_go = 1'b1;
               valid_in[hit_ff] = 1'b0; short_in[hit_ff] = 1'b0;
            end
            rv_in = 1'b1; state_in = FSM_IDLE;
         end
         FSM_RESP: begin
            rd_in = '0;
            if (cmd_ff == CMD_ADD) rd_in[1:0] = found_ff ? ST_DUPLICATE : ST_FULL;
            else rd_in[1:0] = ST_NOT_FOUND;
            rv_in = 1'b1; state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (add_go && valid_ff[i]) m_stamp[i] <= m_stamp[i] + 16'd1;
         if (del_go && valid_ff[i] && m_stamp[i] > hstamp_ff)
            m_stamp[i] <= m_stamp[i] - 16'd1;
      end
      if (add_go) begin
         m_hop[free_ff] <= id_ff; m_emin[free_ff] <= emin_ff;
         m_hops[free_ff] <= hops_ff; m_avg[free_ff] <= avg_ff;
         m_tra[free_ff] <= tra_ff; m_score[free_ff] <= score;
         m_stamp[free_ff] <= 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE; rv_ff <= 1'b0; valid_ff <= '0; short_ff <= '0;
         icnt_ff <= 16'd0; idx_ff <= '0; found_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; valid_ff <= valid_in;
         short_ff <= short_in; icnt_ff <= icnt_in; idx_ff <= idx_in;
         found_ff <= found_in;
      end
      cmd_ff <= cmd_in; id_ff <= id_in; emin_ff <= emin_in; avg_ff <= avg_in;
      tra_ff <= tra_in; hops_ff <= hops_in; bud_ff <= bud_in;
      free_ok_ff <= free_ok_in; any_ff <= any_in; anys_ff <= anys_in;
      hit_ff <= hit_in; free_ff <= free_in; bscore_ff <= bscore_in;
      bstamp_ff <= bstamp_in; hstamp_ff <= hstamp_in; rd_ff <= rd_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   `EART_ASSERT_IMPL(a_busy_no_ready, clock, reset, state_ff != FSM_IDLE, !req_tready)
   `EART_ASSERT_NEXT(a_div_done_write, clock, reset, div_done && state_ff == FSM_DIV,
                     state_ff == FSM_WRITE)
   `EART_ASSERT_NEXT(a_add_fills, clock, reset, add_go, valid_ff != '0)
endmodule
`default_nettype wire

### test/tb_energy_aware_route_table_unit.sv
`timescale 1ns / 1ps
module tb_energy_aware_route_table_unit;
   import eart_pkg::*;

   localparam int Slots = 16;
   localparam int CycleLimit = 400000;

   typedef struct packed {
      logic signed [7:0] budget;
      logic [15:0] traffic;
      logic [15:0] avg;
      logic [7:0]  hops;
      logic [15:0] emin;
      logic [15:0] id;
      cmd_type     cmd;
   } route_req_t;

   typedef struct packed {
      logic        shortest;
      logic [31:0] score;
      logic [15:0] traffic;
      logic [15:0] avg;
      logic [7:0]  hops;
      logic [15:0] emin;
      logic [15:0] id;
      status_type  status;
   } route_rsp_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RspDataWidth-1:0] rsp_tdata;

   energy_aware_route_table_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // route table shadow
   logic        t_valid [Slots];
   logic        t_short [Slots];
   logic [15:0] t_id [Slots];
   logic [15:0] t_emin [Slots];
   logic [7:0]  t_hops [Slots];
   logic [15:0] t_avg [Slots];
   logic [15:0] t_traf [Slots];
   logic [31:0] t_score [Slots];
   int          t_age [Slots];

   route_req_t pending_reqs[$];
   route_rsp_t expected_rsps[$];
   int  errors = 0;
   int  cycles = 0;
   bit  quiet = 0;
   bit  hold_send = 0;
   int  send_gap = 0;
   int  recv_gap = 0;

   function automatic logic [31:0] route_score(logic [15:0] avg, logic [7:0] hops,
                                               logic [15:0] traf);
      logic [47:0] dv;
      logic [47:0] q;
      dv = hops * traf;
      if (dv == 0) return 32'hFFFF_FFFF;
      q = {avg, 16'h0} / dv;
      if (q > 48'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return q[31:0];
   endfunction

   function automatic route_rsp_t slot_rsp(int i);
      route_rsp_t r;
      r.status = ST_OK; r.id = t_id[i]; r.emin = t_emin[i]; r.hops = t_hops[i];
      r.avg = t_avg[i]; r.traffic = t_traf[i]; r.score = t_score[i];
      r.shortest = t_short[i];
      return r;
   endfunction

   function automatic route_rsp_t fail_rsp(status_type s);
      route_rsp_t r;
      r = '0;
      r.status = s;
      return r;
   endfunction

   function automatic int lookup(logic [15:0] id);
      for (int i = 0; i < Slots; i++)
         if (t_valid[i] && t_id[i] == id) return i;
      return -1;
   endfunction

   function automatic route_rsp_t route_apply(route_req_t q);
      int hit;
      int free_slot;
      bit any;
      bit any_short;
      bit sh;
      hit = -1; free_slot = -1; any = 0; any_short = 0;
      case (q.cmd)
         CMD_ADD: begin
            if (lookup(q.id) >= 0) return fail_rsp(ST_DUPLICATE);
            for (int i = 0; i < Slots; i++)
               if (t_valid[i]) begin
                  any = 1;
                  if (t_short[i]) any_short = 1;
               end else if (free_slot < 0) free_slot = i;
            if (free_slot < 0) return fail_rsp(ST_FULL);
            sh = !any ? 1 : (q.budget > 0) ? !any_short : 0;
            for (int i = 0; i < Slots; i++)
               if (t_valid[i]) t_age[i]++;
            t_valid[free_slot] = 1; t_short[free_slot] = sh;
            t_id[free_slot] = q.id; t_emin[free_slot] = q.emin;
            t_hops[free_slot] = q.hops; t_avg[free_slot] = q.avg;
            t_traf[free_slot] = q.traffic;
            t_score[free_slot] = route_score(q.avg, q.hops, q.traffic);
            t_age[free_slot] = 0;
            return slot_rsp(free_slot);
         end
         CMD_DELETE, CMD_FIND: begin
            hit = lookup(q.id);
            if (hit < 0) return fail_rsp(ST_NOT_FOUND);
            slot_rsp_hold: begin
               route_rsp_t r;
               r = slot_rsp(hit);
               if (q.cmd == CMD_DELETE) begin
                  for (int i = 0; i < Slots; i++)
                     if (t_valid[i] && t_age[i] > t_age[hit]) t_age[i]--;
                  t_valid[hit] = 0; t_short[hit] = 0;
               end
               return r;
            end
         end
         default: begin
            for (int i = 0; i < Slots; i++) begin
               if (!t_valid[i] || t_score[i] == 0) continue;
               if (t_emin[i] * 32'd10 <= {16'h0, t_avg[i]}) continue;
               if (hit < 0 || t_score[i] > t_score[hit] ||
                   (t_score[i] == t_score[hit] && t_age[i] < t_age[hit]))
                  hit = i;
            end
            if (hit < 0) return fail_rsp(ST_NOT_FOUND);
            return slot_rsp(hit);
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h", what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(route_apply(route_req_t'(req_tdata[81:0])));
            void'(pending_reqs.pop_front());
         end
         if (req_tvalid && !req_tready) begin
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 8) - 1;
            req_tvalid <= 0;
         end else if (!hold_send && pending_reqs.size() > 0) begin
            req_tvalid <= 1;
            req_tdata <= {6'b0, pending_reqs[0]};
         end else req_tvalid <= 0;
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 8) - 1;
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         route_rsp_t got;
         route_rsp_t want;
         got = route_rsp_t'(rsp_tdata[106:0]);
         if (expected_rsps.size() == 0)
            report_mismatch("unexpected beat", 128'(rsp_tdata), 128'(0));
         else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 128'(got.status), 128'(want.status));
            if (got.id !== want.id) report_mismatch("route_id", 128'(got.id), 128'(want.id));
            if (got.emin !== want.emin)
               report_mismatch("min_energy", 128'(got.emin), 128'(want.emin));
            if (got.hops !== want.hops)
               report_mismatch("hops", 128'(got.hops), 128'(want.hops));
            if (got.avg !== want.avg)
               report_mismatch("avg_energy", 128'(got.avg), 128'(want.avg));
            if (got.traffic !== want.traffic)
               report_mismatch("traffic", 128'(got.traffic), 128'(want.traffic));
            if (got.score !== want.score)
               report_mismatch("score", 128'(got.score), 128'(want.score));
            if (got.shortest !== want.shortest)
               report_mismatch("shortest", 128'(got.shortest), 128'(want.shortest));
         end
      end
      if (cycles > CycleLimit) begin
         $display("tb_energy_aware_route_table_unit failed");
         $finish;
      end
   end

   function automatic route_req_t mk(cmd_type c, logic [15:0] id);
      route_req_t q;
      q.cmd = c; q.id = id;
      q.emin = 16'($urandom); q.hops = 8'($urandom); q.avg = 16'($urandom);
      q.traffic = 16'($urandom); q.budget = 8'($urandom);
      return q;
   endfunction

   initial begin
      route_req_t q;
      for (int i = 0; i < Slots; i++) begin
         t_valid[i] = 0; t_short[i] = 0; t_age[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed
      pending_reqs.push_back(mk(CMD_BEST, 0));
      pending_reqs.push_back(mk(CMD_FIND, 16'hFFFF));
      pending_reqs.push_back(mk(CMD_DELETE, 0));
      q = mk(CMD_ADD, 16'hFFFF); q.hops = 0; q.budget = -128;
      pending_reqs.push_back(q);
      q = mk(CMD_ADD, 16'hFFFF);
      pending_reqs.push_back(q);
      q = mk(CMD_ADD, 0); q.hops = 8'hFF; q.traffic = 16'hFFFF; q.avg = 16'hFFFF;
      q.emin = 16'hFFFF; q.budget = 127;
      pending_reqs.push_back(q);
      q = mk(CMD_ADD, 1); q.hops = 1; q.traffic = 1; q.avg = 0; q.emin = 0; q.budget = 0;
      pending_reqs.push_back(q);
      q = mk(CMD_ADD, 2); q.hops = 1; q.traffic = 16'h100; q.avg = 16'h100;
      q.emin = 16'h100; q.budget = 1;
      pending_reqs.push_back(q);
      q = mk(CMD_ADD, 3); q.hops = 1; q.traffic = 16'h100; q.avg = 16'h100;
      q.emin = 16'h100; q.budget = 1;
      pending_reqs.push_back(q);
      pending_reqs.push_back(mk(CMD_BEST, 0));
      pending_reqs.push_back(mk(CMD_FIND, 0));
      pending_reqs.push_back(mk(CMD_DELETE, 16'hFFFF));
      q = mk(CMD_ADD, 4); q.budget = 5;
      pending_reqs.push_back(q);
      for (int i = 5; i < 20; i++) pending_reqs.push_back(mk(CMD_ADD, 16'(i)));
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      hold_send = 1;
      repeat (30) @(posedge clock);
      hold_send = 0;
      // random, small id pool to hit duplicates and full table
      for (int n = 0; n < 800; n++) begin
         q = mk(cmd_type'($urandom_range(0, 3)), 16'($urandom_range(0, 23)));
         if ($urandom_range(0, 19) == 0) q.id = 16'($urandom);
         if ($urandom_range(0, 3) == 0) q.emin = 16'($urandom_range(0, 16'h2000));
         if ($urandom_range(0, 5) == 0) q.hops = 8'($urandom_range(0, 2));
         if ($urandom_range(0, 5) == 0) q.traffic = 16'($urandom_range(0, 3));
         if (n == 700) begin
            wait (pending_reqs.size() == 0);
            quiet = 1;
         end
         pending_reqs.push_back(q);
      end
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("tb_energy_aware_route_table_unit passed");
      else
         $display("tb_energy_aware_route_table_unit failed");
      $finish;
   end
endmodule

### files.f
+incdir+rtl
rtl/eart_pkg.sv
rtl/eart_divider.sv
rtl/energy_aware_route_table_unit.sv
test/tb_energy_aware_route_table_unit.sv
